// ===== hw/rtl/gbn_pkg.sv =====
// Shared types and constants for the go-back-N sender.
// Used by every module in hw/rtl; depends on nothing else.
`timescale 1ns / 1ps
`default_nettype none

package gbn_pkg;

  localparam int PAY_W       = 64;
  localparam int BSUM_W      = 11;
  localparam int FIELD_SEQ_W = 16;
  localparam int CKSUM_IN_W  = 19;
  localparam int CKSUM_OUT_W = 18;
  localparam int WIN_W       = 5;
  localparam int WIN_MAX     = 16;
  localparam int WIN_RESET   = 10;
  localparam int Q_DEPTH     = 2;

  localparam int IN_TDATA_W  = 120;
  localparam int IN_TUSER_W  = 2;
  localparam int OUT_TDATA_W = 104;
  localparam int OUT_TUSER_W = 5;

  localparam int APB_ADDR_W  = 3;
  localparam int APB_DATA_W  = 32;
  localparam logic [APB_ADDR_W-1:0] ADDR_WINDOW_SIZE = 3'd0;

  typedef enum logic [1:0] {
    CMD_MSG   = 2'd0,
    CMD_ACK   = 2'd1,
    CMD_TIMER = 2'd2,
    CMD_NONE  = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    EV_MSG     = 2'd0,
    EV_ACK_OK  = 2'd1,
    EV_ACK_BAD = 2'd2,
    EV_TIMER   = 2'd3
  } ev_kind_t;

  typedef enum logic [1:0] {
    TMR_NONE    = 2'd0,
    TMR_START   = 2'd1,
    TMR_STOP    = 2'd2,
    TMR_RESTART = 2'd3
  } timer_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_DROPPED   = 2'd1,
    ST_BAD_CKSUM = 2'd2,
    ST_ACK_RANGE = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    BK_IDLE,
    BK_CHECK,
    BK_READ,
    BK_EMIT,
    BK_EMPTY
  } back_state_t;

  // Classified event handed from the front end to the back end.
  typedef struct packed {
    ev_kind_t                  kind;
    logic [PAY_W-1:0]          payload;
    logic signed [BSUM_W-1:0]  bsum;
    logic [FIELD_SEQ_W-1:0]    pkt_ack;
  } event_t;

  // One word of the payload ring: payload and its signed byte sum.
  typedef struct packed {
    logic signed [BSUM_W-1:0]  bsum;
    logic [PAY_W-1:0]          payload;
  } entry_t;

  // One result transaction.
  typedef struct packed {
    logic                          send_valid;
    logic [FIELD_SEQ_W-1:0]        seq;
    logic signed [CKSUM_OUT_W-1:0] checksum;
    logic [PAY_W-1:0]              payload;
    timer_t                        timer;
    status_t                       status;
    logic                          last;
  } result_t;

endpackage

`default_nettype wire

// ===== hw/rtl/gbn_front.sv =====
// Front end of the go-back-N sender: takes input transactions, computes the
// payload byte sum and the acknowledgment checksum check. Depends on gbn_pkg.
`timescale 1ns / 1ps
`default_nettype none

module gbn_front #(
  parameter int PAYLOAD_BYTES = 8
) (
  input  wire                              clk,
  input  wire                              rst,
  input  wire                              s_tvalid,
  output logic                             s_tready,
  // payload[63:0], pkt_seq[79:64], pkt_ack[95:80], pkt_checksum[114:96]
  input  wire  [gbn_pkg::IN_TDATA_W-1:0]   s_tdata,
  // cmd[1:0]
  input  wire  [gbn_pkg::IN_TUSER_W-1:0]   s_tuser,
  input  wire                              q_full,
  output logic                             push,
  output gbn_pkg::event_t                  push_data
);
  import gbn_pkg::*;

  localparam logic [PAY_W-1:0] PAY_MASK = (PAYLOAD_BYTES >= 8) ? {PAY_W{1'b1}} :
      ((64'd1 << (8 * PAYLOAD_BYTES)) - 64'd1);

  logic [PAY_W-1:0]              payload;
  logic [FIELD_SEQ_W-1:0]        pkt_seq;
  logic [FIELD_SEQ_W-1:0]        pkt_ack;
  logic signed [CKSUM_IN_W-1:0]  pkt_checksum;
  cmd_t                          cmd;
  logic signed [BSUM_W-1:0]      bsum;
  logic signed [CKSUM_IN_W-1:0]  calc;
  logic                          cksum_ok;
  logic                          busy_q;

  assign payload      = s_tdata[63:0] & PAY_MASK;
  assign pkt_seq      = s_tdata[79:64];
  assign pkt_ack      = s_tdata[95:80];
  assign pkt_checksum = signed'(s_tdata[114:96]);
  assign cmd          = cmd_t'(s_tuser);

  // Sum of the payload bytes, each read as a signed byte.
  always_comb begin
    bsum = '0;
    for (int i = 0; i < 8; i++) begin
      if (i < PAYLOAD_BYTES) begin
        bsum = bsum + BSUM_W'(signed'(payload[8*i +: 8]));
      end
    end
  end

  assign calc     = CKSUM_IN_W'(pkt_ack) + CKSUM_IN_W'(pkt_seq) + CKSUM_IN_W'(bsum);
  assign cksum_ok = (calc == pkt_checksum);

  // Hold off input for the cycle after reset so the queue is settled.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy_q <= 1'b1;
    end else begin
      busy_q <= 1'b0;
    end
  end

  assign s_tready = !q_full && !busy_q;
  assign push     = s_tvalid && s_tready && (cmd != CMD_NONE);

  always_comb begin
    push_data.payload = payload;
    push_data.bsum    = bsum;
    push_data.pkt_ack = pkt_ack;
    case (cmd)
      CMD_MSG:   push_data.kind = EV_MSG;
      CMD_ACK:   push_data.kind = cksum_ok ? EV_ACK_OK : EV_ACK_BAD;
      CMD_TIMER: push_data.kind = EV_TIMER;
      default:   push_data.kind = EV_TIMER;
    endcase
  end

endmodule

`default_nettype wire

// ===== hw/rtl/gbn_queue.sv =====
// Two-entry event queue between the front end and the back end.
// Depends on gbn_pkg.
`timescale 1ns / 1ps
`default_nettype none

module gbn_queue (
  input  wire              clk,
  input  wire              rst,
  input  wire              push,
  input  gbn_pkg::event_t  push_data,
  output logic             full,
  input  wire              pop,
  output gbn_pkg::event_t  pop_data,
  output logic             empty
);
  import gbn_pkg::*;

  localparam int PTR_W = $clog2(Q_DEPTH);
  localparam int CNT_W = $clog2(Q_DEPTH + 1);

  event_t             slots [Q_DEPTH];
  logic [PTR_W-1:0]   wr_ptr;
  logic [PTR_W-1:0]   rd_ptr;
  logic [CNT_W-1:0]   count;
  logic               do_push;
  logic               do_pop;

  assign full     = (count == CNT_W'(Q_DEPTH));
  assign empty    = (count == '0);
  assign do_push  = push && !full;
  assign do_pop   = pop && !empty;
  assign pop_data = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PTR_W'(Q_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(Q_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/gbn_back.sv =====
// Back end of the go-back-N sender: window state, payload ring and the
// sequencer that emits result transactions. Depends on gbn_pkg.
`timescale 1ns / 1ps
`default_nettype none

module gbn_back #(
  parameter int STORE_DEPTH = 16,
  parameter int SEQ_BITS    = 16
) (
  input  wire                          clk,
  input  wire                          rst,
  input  gbn_pkg::event_t              q_data,
  input  wire                          q_empty,
  output logic                         q_pop,
  input  wire  [gbn_pkg::WIN_W-1:0]    window_size,
  output gbn_pkg::result_t             res,
  output logic                         res_valid,
  input  wire                          res_ready
);
  import gbn_pkg::*;

  localparam int CLOG_DEPTH = $clog2(STORE_DEPTH);
  localparam int IDX_W      = (CLOG_DEPTH < SEQ_BITS) ? CLOG_DEPTH : SEQ_BITS;
  localparam int MEM_DEPTH  = 1 << IDX_W;
  localparam longint unsigned SEQ_MAX  = (64'd1 << SEQ_BITS) - 64'd1;
  localparam longint unsigned FULL_LIM =
      (64'(STORE_DEPTH) < SEQ_MAX) ? 64'(STORE_DEPTH) : SEQ_MAX;

  back_state_t         state, state_next;
  logic [SEQ_BITS-1:0] base, base_next;
  logic [SEQ_BITS-1:0] nts, nts_next;
  logic [SEQ_BITS-1:0] nta, nta_next;
  logic [SEQ_BITS-1:0] scan, scan_next;
  logic [SEQ_BITS-1:0] tx_seq, tx_seq_next;
  logic                tx_start, tx_start_next;
  ev_kind_t            op, op_next;
  timer_t              empty_timer, empty_timer_next;
  status_t             empty_status, empty_status_next;
  result_t             res_next;
  logic                res_valid_next;

  entry_t              mem [MEM_DEPTH];
  entry_t              rd_data;
  logic                wr_en;
  logic                rd_en;
  logic [IDX_W-1:0]    rd_addr;

  logic [WIN_W-1:0]    win_eff;
  logic [SEQ_BITS-1:0] in_flight;
  logic [SEQ_BITS-1:0] queued;
  logic [SEQ_BITS-1:0] pack_s;
  logic [SEQ_BITS-1:0] ack_dist;
  logic                store_full;
  logic                ack_range_bad;
  logic                can_send;
  logic                more;
  logic                res_free;

  assign win_eff = (window_size == '0) ? WIN_W'(1) :
                   (window_size > WIN_W'(WIN_MAX)) ? WIN_W'(WIN_MAX) : window_size;

  assign in_flight     = nts - base;
  assign queued        = nta - base;
  assign pack_s        = SEQ_BITS'(q_data.pkt_ack);
  assign ack_dist      = pack_s - base;
  assign store_full    = 33'(queued) >= 33'(FULL_LIM);
  assign ack_range_bad = (33'(q_data.pkt_ack) > 33'(SEQ_MAX)) || (ack_dist >= in_flight);
  assign can_send      = (nts != nta) && (in_flight < SEQ_BITS'(win_eff));
  assign more          = (op == EV_TIMER) ? (scan != nts) : can_send;
  assign res_free      = !res_valid || res_ready;

  // Payload ring, indexed by the low bits of the sequence number.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[nta[IDX_W-1:0]] <= '{bsum: q_data.bsum, payload: q_data.payload};
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

  // Next state.
  always_comb begin
    state_next = state;
    case (state)
      BK_IDLE: begin
        if (!q_empty) begin
          case (q_data.kind)
            EV_MSG:     state_next = store_full ? BK_EMPTY : BK_CHECK;
            EV_ACK_OK:  state_next = ack_range_bad ? BK_EMPTY : BK_CHECK;
            EV_ACK_BAD: state_next = BK_EMPTY;
            EV_TIMER:   state_next = (base == nts) ? BK_EMPTY : BK_READ;
            default:    state_next = BK_EMPTY;
          endcase
        end
      end
      BK_CHECK: state_next = can_send ? BK_READ : BK_EMPTY;
      BK_READ:  state_next = BK_EMIT;
      BK_EMIT: begin
        if (res_free) begin
          state_next = more ? BK_READ : BK_IDLE;
        end
      end
      BK_EMPTY: begin
        if (res_free) begin
          state_next = BK_IDLE;
        end
      end
      default: state_next = BK_IDLE;
    endcase
  end

  // Datapath and outputs.
  always_comb begin
    base_next         = base;
    nts_next          = nts;
    nta_next          = nta;
    scan_next         = scan;
    tx_seq_next       = tx_seq;
    tx_start_next     = tx_start;
    op_next           = op;
    empty_timer_next  = empty_timer;
    empty_status_next = empty_status;
    res_next          = res;
    res_valid_next    = res_valid && !res_ready;
    q_pop             = 1'b0;
    wr_en             = 1'b0;
    rd_en             = 1'b0;
    rd_addr           = nts[IDX_W-1:0];

    case (state)
      BK_IDLE: begin
        if (!q_empty) begin
          q_pop             = 1'b1;
          op_next           = q_data.kind;
          empty_timer_next  = TMR_NONE;
          empty_status_next = ST_OK;
          case (q_data.kind)
            EV_MSG: begin
              if (store_full) begin
                empty_status_next = ST_DROPPED;
              end else begin
                wr_en    = 1'b1;
                nta_next = nta + 1'b1;
              end
            end
            EV_ACK_OK: begin
              if (ack_range_bad) begin
                empty_status_next = ST_ACK_RANGE;
              end else begin
                base_next = pack_s + 1'b1;
              end
            end
            EV_ACK_BAD: empty_status_next = ST_BAD_CKSUM;
            EV_TIMER:   scan_next = base;
            default:    empty_status_next = ST_OK;
          endcase
        end
      end
      BK_CHECK: begin
        // Nothing to send: an accepted ack still reports the timer.
        if (op == EV_ACK_OK) begin
          empty_timer_next = (base == nts) ? TMR_STOP : TMR_RESTART;
        end
      end
      BK_READ: begin
        rd_en = 1'b1;
        if (op == EV_TIMER) begin
          rd_addr       = scan[IDX_W-1:0];
          tx_seq_next   = scan;
          scan_next     = scan + 1'b1;
          tx_start_next = 1'b0;
        end else begin
          tx_seq_next   = nts;
          nts_next      = nts + 1'b1;
          tx_start_next = (op == EV_MSG) && (nts == base);
        end
      end
      BK_EMIT: begin
        if (res_free) begin
          res_valid_next      = 1'b1;
          res_next.send_valid = 1'b1;
          res_next.seq        = FIELD_SEQ_W'(tx_seq);
          res_next.checksum   = CKSUM_OUT_W'(tx_seq) - CKSUM_OUT_W'(1)
                                + CKSUM_OUT_W'(rd_data.bsum);
          res_next.payload    = rd_data.payload;
          res_next.status     = ST_OK;
          res_next.last       = !more;
          if (op == EV_TIMER) begin
            res_next.timer = more ? TMR_NONE : TMR_START;
          end else if (tx_start) begin
            res_next.timer = TMR_START;
          end else if (op == EV_ACK_OK && !more) begin
            res_next.timer = (base == nts) ? TMR_STOP : TMR_RESTART;
          end else begin
            res_next.timer = TMR_NONE;
          end
        end
      end
      BK_EMPTY: begin
        if (res_free) begin
          res_valid_next      = 1'b1;
          res_next.send_valid = 1'b0;
          res_next.seq        = '0;
          res_next.checksum   = '0;
          res_next.payload    = '0;
          res_next.timer      = empty_timer;
          res_next.status     = empty_status;
          res_next.last       = 1'b1;
        end
      end
      default: res_valid_next = res_valid && !res_ready;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= BK_IDLE;
      base      <= SEQ_BITS'(1);
      nts       <= SEQ_BITS'(1);
      nta       <= SEQ_BITS'(1);
      res_valid <= 1'b0;
    end else begin
      state     <= state_next;
      base      <= base_next;
      nts       <= nts_next;
      nta       <= nta_next;
      res_valid <= res_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    scan         <= scan_next;
    tx_seq       <= tx_seq_next;
    tx_start     <= tx_start_next;
    op           <= op_next;
    empty_timer  <= empty_timer_next;
    empty_status <= empty_status_next;
    res          <= res_next;
  end

endmodule

`default_nettype wire

// ===== hw/rtl/go_back_n_sender.sv =====
// Top level of the go-back-N sender: stream ports, the window_size register
// on an APB port, and the front end, event queue and back end below it.
// Depends on gbn_pkg, gbn_front, gbn_queue and gbn_back.
`timescale 1ns / 1ps
`default_nettype none

// Go-back-N sender. Each input transaction is one event, chosen by s_tuser:
// an application message, which is stored in the payload ring and sent if
// the window has room; an acknowledgment, whose additive checksum is checked
// and which moves the window base past the acknowledged number; or a timer
// expiry, which resends every outstanding packet. Each event gives one or
// more output transactions, the final one marked by m_tlast; each carries an
// optional data packet, a timer command and a status. Events with command
// code 3 are accepted and give no output. The front end classifies an event
// in the cycle it is accepted and queues it (two deep), so input can keep
// flowing while the back end works. The back end passes an accepted message
// or acknowledgment through a check state, and a timer expiry goes straight
// to the reads; each data packet is a registered read of the payload ring
// then an emit state, and an event without packets ends in an empty result.
// Results sit in an output register, so the sender stalls only while that
// register is full and not taken. The payload ring has no reset and needs
// no clearing pass: only entries that were written are ever read.
// STORE_DEPTH should be a power of two no larger than 2^SEQ_BITS, so that
// the ring index is the low bits of the sequence number. window_size lies at
// byte address 0; a value of 0 acts as 1 and values above 16 act as 16.
module go_back_n_sender #(
  parameter int STORE_DEPTH   = 16,
  parameter int SEQ_BITS      = 16,
  parameter int PAYLOAD_BYTES = 8
) (
  input  wire                               clk,
  input  wire                               rst,
  // Input events.
  input  wire                               s_tvalid,
  output logic                              s_tready,
  // payload[63:0], pkt_seq[79:64], pkt_ack[95:80], pkt_checksum[114:96]
  input  wire  [gbn_pkg::IN_TDATA_W-1:0]    s_tdata,
  // cmd[1:0]
  input  wire  [gbn_pkg::IN_TUSER_W-1:0]    s_tuser,
  // Results.
  output logic                              m_tvalid,
  input  wire                               m_tready,
  // out_seq[15:0], out_checksum[33:16], out_payload[97:34], zero[103:98]
  output logic [gbn_pkg::OUT_TDATA_W-1:0]   m_tdata,
  // send_valid[0], timer_action[2:1], status[4:3]
  output logic [gbn_pkg::OUT_TUSER_W-1:0]   m_tuser,
  output logic                              m_tlast,
  // Configuration.
  input  wire                               psel,
  input  wire                               penable,
  input  wire                               pwrite,
  input  wire  [gbn_pkg::APB_ADDR_W-1:0]    paddr,
  input  wire  [gbn_pkg::APB_DATA_W-1:0]    pwdata,
  output logic [gbn_pkg::APB_DATA_W-1:0]    prdata,
  output logic                              pready
);
  import gbn_pkg::*;

  logic [WIN_W-1:0] window_size;
  logic             q_full;
  logic             q_empty;
  logic             q_push;
  logic             q_pop;
  event_t           push_data;
  event_t           pop_data;
  result_t          res;

  // The window register is written on the access phase of an APB write.
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      window_size <= WIN_W'(WIN_RESET);
    end else if (psel && penable && pwrite && (paddr == ADDR_WINDOW_SIZE)) begin
      window_size <= pwdata[WIN_W-1:0];
    end
  end

  assign prdata = (paddr == ADDR_WINDOW_SIZE) ? APB_DATA_W'(window_size) : '0;

  gbn_front #(
    .PAYLOAD_BYTES(PAYLOAD_BYTES)
  ) u_front (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .q_full   (q_full),
    .push     (q_push),
    .push_data(push_data)
  );

  gbn_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (q_push),
    .push_data(push_data),
    .full     (q_full),
    .pop      (q_pop),
    .pop_data (pop_data),
    .empty    (q_empty)
  );

  gbn_back #(
    .STORE_DEPTH(STORE_DEPTH),
    .SEQ_BITS   (SEQ_BITS)
  ) u_back (
    .clk        (clk),
    .rst        (rst),
    .q_data     (pop_data),
    .q_empty    (q_empty),
    .q_pop      (q_pop),
    .window_size(window_size),
    .res        (res),
    .res_valid  (m_tvalid),
    .res_ready  (m_tready)
  );

  // Results are packed onto the stream from the lowest field up.
  assign m_tdata = {6'b0, res.payload, res.checksum, res.seq};
  assign m_tuser = {res.status, res.timer, res.send_valid};
  assign m_tlast = res.last;

endmodule

`default_nettype wire
